// File: sv/gds_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date stepper.
// No dependencies; imported by every module of the block except the checker.

package gds_pkg;

    // Transaction op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SHIFT = 2'd1;
    localparam logic [1:0] OP_DIST  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 23;
    localparam int UPC_W   = 4;

    // Calendar constants
    localparam logic [DAY_W-1:0]   DAYS_SHORT = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_LONG  = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_FEB   = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_FEB_L = 5'd29;
    localparam logic [MONTH_W-1:0] MONTHS     = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;

    // floor(y / 100) = (y * 5243) >> 19 for every 14-bit year
    localparam int            RECIP_W   = 13;
    localparam int            RECIP_SH  = 19;
    localparam logic [12:0]   RECIP_100 = 13'd5243;
    localparam int            PROD_W    = YEAR_W + RECIP_W;

    typedef logic [UPC_W-1:0] upc_t;

    // Year in the top bits so a packed compare orders dates
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    localparam date_t DEFAULT_DATE = '{year: 14'd2026, month: 4'd1,  day: 5'd1};
    localparam date_t MIN_DATE     = '{year: 14'd1,    month: 4'd1,  day: 5'd1};
    localparam date_t MAX_DATE     = '{year: 14'd9999, month: 4'd12, day: 5'd31};

    // Datapath actions, one per microcode step
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_VALIDATE,
        ACT_COPY_W,
        ACT_H_STEP,
        ACT_SET_CLAMP,
        ACT_CLR_CNT,
        ACT_W_STEP,
        ACT_EMIT
    } act_t;

    // Jump conditions
    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_OP_SHIFT,
        CND_OP_NOP,
        CND_OP_DIST,
        CND_SHIFT_RUN,
        CND_CNT_ZERO,
        CND_W_NE_H,
        CND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        act_t act;
        logic idle;
    } seq_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic no_input;
        logic op_shift;
        logic op_nop;
        logic op_dist;
        logic shift_run;
        logic cnt_zero;
        logic w_ne_h;
        logic out_blocked;
    } seq_stat_t;

    // 4/100/400 rule; divisibility by 100 read off the reciprocal product
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-RECIP_SH-1:0] q;
        logic div100;
        prod   = PROD_W'(y) * PROD_W'(RECIP_100);
        q      = prod[PROD_W-1:RECIP_SH];
        div100 = (prod[RECIP_SH-1:12] == '0);
        return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
            MONTH_FEB:               len = leap ? DAYS_FEB_L : DAYS_FEB;
            default:                 len = DAYS_LONG;
        endcase
        return len;
    endfunction

    function automatic logic date_ok(input date_t d);
        logic [DAY_W-1:0] len;
        len = month_len(d.month, is_leap(d.year));
        return (d.year != '0) && (d.year <= MAX_YEAR) &&
               (d.month != '0) && (d.month <= MONTHS) &&
               (d.day != '0) && (d.day <= len);
    endfunction

endpackage

// File: sv/gds_cal.sv
// Calendar step unit: moves a valid date one day forward or back.
// Depends on gds_pkg for date_t and the month length helpers.

module gds_cal (
    input  gds_pkg::date_t cur,
    input  logic           down,
    output gds_pkg::date_t nxt
);
    import gds_pkg::*;

    logic                leap;
    logic [MONTH_W-1:0]  prev_month;
    logic [DAY_W-1:0]    len_cur;
    logic [DAY_W-1:0]    len_prev;

    // Month lengths for the current and the preceding month
    assign leap       = is_leap(cur.year);
    assign prev_month = cur.month - 4'd1;
    assign len_cur    = month_len(cur.month, leap);
    assign len_prev   = month_len(prev_month, leap);

    // Roll over day, month and year ends
    always_comb
    begin
        nxt = cur;
        if (!down)
        begin
            if (cur.day < len_cur)
            begin
                nxt.day = cur.day + 5'd1;
            end
            else if (cur.month < MONTHS)
            begin
                nxt.day   = 5'd1;
                nxt.month = cur.month + 4'd1;
            end
            else
            begin
                nxt.day   = 5'd1;
                nxt.month = 4'd1;
                nxt.year  = cur.year + 14'd1;
            end
        end
        else
        begin
            if (cur.day > 5'd1)
            begin
                nxt.day = cur.day - 5'd1;
            end
            else if (cur.month > 4'd1)
            begin
                nxt.month = prev_month;
                nxt.day   = len_prev;
            end
            else
            begin
                nxt.month = MONTHS;
                nxt.day   = DAYS_LONG;
                nxt.year  = cur.year - 14'd1;
            end
        end
    end

endmodule

// File: sv/gds_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on gds_pkg for the control word, action and condition types.

module gds_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  gds_pkg::seq_stat_t stat,
    output gds_pkg::seq_ctl_t  ctl
);
    import gds_pkg::*;

    // Step addresses
    localparam upc_t UA_IDLE   = 4'd0;
    localparam upc_t UA_DISP1  = 4'd1;
    localparam upc_t UA_DISP2  = 4'd2;
    localparam upc_t UA_CHECK  = 4'd3;
    localparam upc_t UA_LOAD   = 4'd4;
    localparam upc_t UA_SHIFT  = 4'd5;
    localparam upc_t UA_SEND   = 4'd6;
    localparam upc_t UA_CLAMP  = 4'd7;
    localparam upc_t UA_DCLR   = 4'd8;
    localparam upc_t UA_DWALK  = 4'd9;
    localparam upc_t UA_EMIT   = 4'd10;
    localparam upc_t UA_RET    = 4'd11;

    upc_t   pc_reg;
    upc_t   pc_next;
    uword_t uw;
    logic   jump;

    // Control store
    function automatic uword_t rom_word(input upc_t pc);
        uword_t w;
        unique case (pc)
            UA_IDLE:  w = '{act: ACT_LATCH,     cond: CND_NO_INPUT,    target: UA_IDLE};
            UA_DISP1: w = '{act: ACT_NONE,      cond: CND_OP_SHIFT,    target: UA_SHIFT};
            UA_DISP2: w = '{act: ACT_NONE,      cond: CND_OP_NOP,      target: UA_EMIT};
            UA_CHECK: w = '{act: ACT_VALIDATE,  cond: CND_OP_DIST,     target: UA_DCLR};
            UA_LOAD:  w = '{act: ACT_COPY_W,    cond: CND_ALWAYS,      target: UA_EMIT};
            UA_SHIFT: w = '{act: ACT_H_STEP,    cond: CND_SHIFT_RUN,   target: UA_SHIFT};
            UA_SEND:  w = '{act: ACT_NONE,      cond: CND_CNT_ZERO,    target: UA_EMIT};
            UA_CLAMP: w = '{act: ACT_SET_CLAMP, cond: CND_ALWAYS,      target: UA_EMIT};
            UA_DCLR:  w = '{act: ACT_CLR_CNT,   cond: CND_NEVER,       target: UA_IDLE};
            UA_DWALK: w = '{act: ACT_W_STEP,    cond: CND_W_NE_H,      target: UA_DWALK};
            UA_EMIT:  w = '{act: ACT_EMIT,      cond: CND_OUT_BLOCKED, target: UA_EMIT};
            UA_RET:   w = '{act: ACT_NONE,      cond: CND_ALWAYS,      target: UA_IDLE};
            default:  w = '{act: ACT_NONE,      cond: CND_ALWAYS,      target: UA_IDLE};
        endcase
        return w;
    endfunction

    assign uw = rom_word(pc_reg);

    // Condition select
    always_comb
    begin
        case (uw.cond)
            CND_NEVER:       jump = 1'b0;
            CND_ALWAYS:      jump = 1'b1;
            CND_NO_INPUT:    jump = stat.no_input;
            CND_OP_SHIFT:    jump = stat.op_shift;
            CND_OP_NOP:      jump = stat.op_nop;
            CND_OP_DIST:     jump = stat.op_dist;
            CND_SHIFT_RUN:   jump = stat.shift_run;
            CND_CNT_ZERO:    jump = stat.cnt_zero;
            CND_W_NE_H:      jump = stat.w_ne_h;
            CND_OUT_BLOCKED: jump = stat.out_blocked;
            default:         jump = 1'b0;
        endcase
    end

    assign pc_next  = jump ? uw.target : pc_reg + 4'd1;
    assign ctl.act  = uw.act;
    assign ctl.idle = (pc_reg == UA_IDLE);

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UA_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: sv/gregorian_date_stepper.sv
// Gregorian date stepper: holds a date, loads it, shifts it by signed days and
// measures the day distance to a supplied date, one day per cycle.
// Shift and distance walk the calendar step unit day by day; a shift that reaches
// 01/01/0001 or 31/12/9999 with days left stops there and reports clamped.
// The next request is taken only after the result has been issued.
// Reset (asynchronous, active low) gives 01/01/2026 and an idle sequencer.

module gregorian_date_stepper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [13:0] year_in,
    input  logic signed [22:0] day_count,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [13:0] year_out,
    output logic signed [22:0] distance,
    output logic        held_is_earlier,
    output logic        dates_equal,
    output logic        input_invalid,
    output logic        clamped
);
    import gds_pkg::*;

    seq_ctl_t  ctl;
    seq_stat_t stat;

    date_t                      h_reg, h_next;
    date_t                      w_reg, w_next;
    logic signed [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]                 op_reg, op_next;
    logic                       inv_reg, inv_next;
    logic                       clamp_reg, clamp_next;

    logic                       rsp_valid_reg, rsp_valid_next;
    date_t                      rdate_reg, rdate_next;
    logic signed [COUNT_W-1:0]  rdist_reg, rdist_next;
    logic                       rearly_reg, rearly_next;
    logic                       requal_reg, requal_next;
    logic                       rinv_reg, rinv_next;
    logic                       rclamp_reg, rclamp_next;

    date_t  step_src;
    date_t  step_dst;
    logic   step_down;
    logic   w_lt_h;
    logic   emit_fire;
    logic   is_dist;

    // Sequencer
    gds_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Shared calendar step unit
    assign w_lt_h    = (w_reg < h_reg);
    assign step_src  = (ctl.act == ACT_W_STEP) ? w_reg : h_reg;
    assign step_down = (ctl.act == ACT_W_STEP) ? !w_lt_h : cnt_reg[COUNT_W-1];

    gds_cal u_cal (
        .cur  (step_src),
        .down (step_down),
        .nxt  (step_dst)
    );

    // Status for the jump conditions
    always_comb
    begin
        stat.no_input    = !req_valid;
        stat.op_shift    = (op_reg == OP_SHIFT);
        stat.op_nop      = (op_reg == OP_NOP);
        stat.op_dist     = (op_reg == OP_DIST);
        stat.cnt_zero    = (cnt_reg == '0);
        stat.shift_run   = !stat.cnt_zero &&
                           !(!cnt_reg[COUNT_W-1] && (h_reg == MAX_DATE)) &&
                           !(cnt_reg[COUNT_W-1] && (h_reg == MIN_DATE));
        stat.w_ne_h      = (w_reg != h_reg);
        stat.out_blocked = rsp_valid_reg && rsp_stall;
    end

    // Datapath actions
    always_comb
    begin
        h_next     = h_reg;
        w_next     = w_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        inv_next   = inv_reg;
        clamp_next = clamp_reg;
        case (ctl.act)
            ACT_LATCH:
            begin
                if (req_valid)
                begin
                    w_next     = '{year: year_in, month: month_in, day: day_in};
                    cnt_next   = day_count;
                    op_next    = op;
                    inv_next   = 1'b0;
                    clamp_next = 1'b0;
                end
            end
            ACT_VALIDATE:
            begin
                if (!date_ok(w_reg))
                begin
                    w_next   = DEFAULT_DATE;
                    inv_next = 1'b1;
                end
            end
            ACT_COPY_W:
            begin
                h_next = w_reg;
            end
            ACT_H_STEP:
            begin
                if (stat.shift_run)
                begin
                    h_next   = step_dst;
                    cnt_next = cnt_reg[COUNT_W-1] ? cnt_reg + 23'sd1 : cnt_reg - 23'sd1;
                end
            end
            ACT_SET_CLAMP:
            begin
                clamp_next = 1'b1;
            end
            ACT_CLR_CNT:
            begin
                cnt_next = '0;
            end
            ACT_W_STEP:
            begin
                if (stat.w_ne_h)
                begin
                    w_next   = step_dst;
                    cnt_next = w_lt_h ? cnt_reg + 23'sd1 : cnt_reg - 23'sd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    assign emit_fire = (ctl.act == ACT_EMIT) && !stat.out_blocked;
    assign is_dist   = (op_reg == OP_DIST);

    always_comb
    begin
        rdate_next  = rdate_reg;
        rdist_next  = rdist_reg;
        rearly_next = rearly_reg;
        requal_next = requal_reg;
        rinv_next   = rinv_reg;
        rclamp_next = rclamp_reg;
        if (emit_fire)
        begin
            rsp_valid_next = 1'b1;
            rdate_next     = h_reg;
            rdist_next     = is_dist ? cnt_reg : '0;
            rearly_next    = is_dist && cnt_reg[COUNT_W-1];
            requal_next    = is_dist && (cnt_reg == '0);
            rinv_next      = inv_reg;
            rclamp_next    = clamp_reg;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= DEFAULT_DATE;
            op_reg        <= OP_NOP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            h_reg         <= h_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        cnt_reg    <= cnt_next;
        inv_reg    <= inv_next;
        clamp_reg  <= clamp_next;
        rdate_reg  <= rdate_next;
        rdist_reg  <= rdist_next;
        rearly_reg <= rearly_next;
        requal_reg <= requal_next;
        rinv_reg   <= rinv_next;
        rclamp_reg <= rclamp_next;
    end

    assign req_stall       = !ctl.idle;
    assign rsp_valid       = rsp_valid_reg;
    assign day_out         = rdate_reg.day;
    assign month_out       = rdate_reg.month;
    assign year_out        = rdate_reg.year;
    assign distance        = rdist_reg;
    assign held_is_earlier = rearly_reg;
    assign dates_equal     = requal_reg;
    assign input_invalid   = rinv_reg;
    assign clamped         = rclamp_reg;

endmodule

// File: sv/gds_checker.sv
// Port-level checks for the Gregorian date stepper, bound to the top level.
// Depends only on the top level's ports.

module gds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic [1:0]  op,
    input logic [4:0]  day_in,
    input logic [3:0]  month_in,
    input logic [13:0] year_in,
    input logic signed [22:0] day_count,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [4:0]  day_out,
    input logic [3:0]  month_out,
    input logic [13:0] year_out,
    input logic signed [22:0] distance,
    input logic        held_is_earlier,
    input logic        dates_equal,
    input logic        input_invalid,
    input logic        clamped
);

    // Held date stays within the representable range
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (day_out != 5'd0) && (month_out != 4'd0) && (month_out <= 4'd12) &&
                      (year_out != 14'd0) && (year_out <= 14'd9999))
        else $error("result date out of range");

    // Earlier and equal flags agree with the distance
    a_flags_dist: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (held_is_earlier == (distance < 0)) &&
                      (!dates_equal || (distance == 0)) &&
                      !(held_is_earlier && dates_equal))
        else $error("distance flags inconsistent");

    // Saturation and an invalid date never come from the same op
    a_clamp_inv: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(clamped && input_invalid))
        else $error("clamped and input_invalid both set");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(day_out) && $stable(month_out) &&
                                   $stable(year_out) && $stable(distance))
        else $error("stalled transaction changed");

endmodule

bind gregorian_date_stepper gds_checker u_gds_checker (.*);
